### rtl/msc_pkg.sv
// msc_pkg: types, constants and the control store for the moisture sample conditioner
// no dependencies; used by every module in rtl but msc_divider

package msc_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int LEVEL_W    = 7;
  localparam int PCT_W      = 18;
  localparam int PCT_SCALE  = 100;
  localparam int SCALE_W    = 7;
  localparam int NUM_MAG_W  = 17;   // |(filtered - dry) * 100| <= 102300
  localparam int DEF_AVG_LENGTH = 8;

  localparam logic [SAMPLE_W-1:0] DRY_RESET = 10'd1023;
  localparam logic [SAMPLE_W-1:0] WET_RESET = 10'd0;

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_USE_AVG   = 2'd0;
  localparam logic [1:0] REG_MIN_LEVEL = 2'd1;
  localparam logic [1:0] REG_DRY_POINT = 2'd2;
  localparam logic [1:0] REG_WET_POINT = 2'd3;

  typedef struct packed {
    logic                use_avg;
    logic [LEVEL_W-1:0]  min_level;
    logic [SAMPLE_W-1:0] dry_point;
    logic [SAMPLE_W-1:0] wet_point;
  } msc_cfg_t;

  // microcode
  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_PASS,
    OP_ACC_HIST,
    OP_ACC_NEW,
    OP_DIV_STEP,
    OP_TAKE_AVG,
    OP_MAP,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_WAIT_IN,
    C_WAIT_OUT,
    C_JMP_NOAVG,
    C_JMP_CAL,
    C_LOOP_IDX,
    C_LOOP_DIV
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  localparam logic [PC_W-1:0] PC_WAIT = 4'd0;
  localparam logic [PC_W-1:0] PC_PASS = 4'd1;
  localparam logic [PC_W-1:0] PC_HIST = 4'd2;
  localparam logic [PC_W-1:0] PC_NEW  = 4'd3;
  localparam logic [PC_W-1:0] PC_DIVA = 4'd4;
  localparam logic [PC_W-1:0] PC_TAKE = 4'd5;
  localparam logic [PC_W-1:0] PC_MAP  = 4'd6;
  localparam logic [PC_W-1:0] PC_DIVM = 4'd7;
  localparam logic [PC_W-1:0] PC_EMIT = 4'd8;

  // control to the datapath
  typedef struct packed {
    op_t  op;
    logic go;
  } msc_ctrl_t;

  // status back to the sequencer
  typedef struct packed {
    logic avg_on;
    logic cal_err;
    logic idx_last;
    logic div_last;
  } msc_stat_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      PC_WAIT: w = '{OP_LATCH,    C_WAIT_IN,   PC_PASS};
      PC_PASS: w = '{OP_PASS,     C_JMP_NOAVG, PC_MAP};
      PC_HIST: w = '{OP_ACC_HIST, C_LOOP_IDX,  PC_HIST};
      PC_NEW:  w = '{OP_ACC_NEW,  C_NEXT,      PC_DIVA};
      PC_DIVA: w = '{OP_DIV_STEP, C_LOOP_DIV,  PC_DIVA};
      PC_TAKE: w = '{OP_TAKE_AVG, C_NEXT,      PC_MAP};
      PC_MAP:  w = '{OP_MAP,      C_JMP_CAL,   PC_EMIT};
      PC_DIVM: w = '{OP_DIV_STEP, C_LOOP_DIV,  PC_DIVM};
      PC_EMIT: w = '{OP_EMIT,     C_WAIT_OUT,  PC_WAIT};
      default: w = '{OP_NOP,      C_JUMP,      PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

### rtl/msc_divider.sv
// msc_divider: restoring unsigned divider, one quotient bit per cycle while step is high
// depends on nothing outside this file

module msc_divider #(
  parameter int DVD_W = 17,
  parameter int DVS_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic             step,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             last
);

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign last  = (cnt_r == CNT_W'(DVD_W - 1));
  assign quotient = quo_r;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (load) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = '0;
    end else if (step) begin
      // trial subtract: keep the difference when the divisor fits
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (load) begin
      dvs_r <= divisor;
    end
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/msc_datapath.sv
// msc_datapath: sample history, weighted accumulator, shared multiplier, mapping and alarm
// depends on msc_pkg and msc_divider

module msc_datapath #(
  parameter int AVG_LENGTH = msc_pkg::DEF_AVG_LENGTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  msc_pkg::msc_ctrl_t            ctrl,
  input  msc_pkg::msc_cfg_t             cfg,
  input  logic [msc_pkg::SAMPLE_W-1:0]  in_sample,
  output msc_pkg::msc_stat_t            stat,
  output logic [msc_pkg::PCT_W-1:0]     moisture_percent,
  output logic [msc_pkg::SAMPLE_W-1:0]  filtered_value,
  output logic                          low_alarm,
  output logic                          calibration_error
);

  import msc_pkg::*;

  localparam int IDX_W    = $clog2(AVG_LENGTH);
  localparam int WGT_W    = $clog2(AVG_LENGTH + 1);
  localparam int WSUM_MAX = AVG_LENGTH * (AVG_LENGTH + 1) / 2;
  localparam int WSUM_W   = $clog2(WSUM_MAX + 1);
  localparam int SUM_W    = $clog2(1023 * WSUM_MAX + 1);
  localparam int DVD_W    = (SUM_W > NUM_MAG_W) ? SUM_W : NUM_MAG_W;
  localparam int DVS_W    = (WSUM_W > SAMPLE_W) ? WSUM_W : SAMPLE_W;
  localparam int MB_W     = (WGT_W > SCALE_W) ? WGT_W : SCALE_W;
  localparam int PROD_W   = SAMPLE_W + MB_W;

  logic [SAMPLE_W-1:0] hist_r [AVG_LENGTH];
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] filt_r;
  logic [IDX_W-1:0]    idx_r;
  logic [SUM_W-1:0]    acc_r;
  logic [WSUM_W-1:0]   wsum_r;
  logic                sign_r;
  logic                alarm_r, alarm_nxt;
  logic [PCT_W-1:0]    moist_r;
  logic [SAMPLE_W-1:0] out_filt_r;
  logic                out_alarm_r;
  logic                out_cal_r;

  logic [IDX_W-1:0]    rd_idx;
  logic [SAMPLE_W-1:0] above;
  logic [WGT_W-1:0]    weight;
  logic [SAMPLE_W-1:0] mul_a;
  logic [MB_W-1:0]     mul_b;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    acc_sum;
  logic                num_neg, den_neg;
  logic [SAMPLE_W-1:0] num_mag, den_mag;
  logic                cal_err;
  logic                div_load, div_step, div_last;
  logic [DVD_W-1:0]    div_dvd;
  logic [DVS_W-1:0]    div_dvs;
  logic [DVD_W-1:0]    div_quo;
  logic [PCT_W-1:0]    quo_pct;
  logic [PCT_W-1:0]    moist_val;

  assign rd_idx  = idx_r + 1'b1;
  assign above   = hist_r[rd_idx];
  assign weight  = WGT_W'(rd_idx);
  assign cal_err = (cfg.wet_point == cfg.dry_point);

  // signed map done on magnitudes, sign applied after the divide
  assign num_neg = (filt_r < cfg.dry_point);
  assign num_mag = num_neg ? (cfg.dry_point - filt_r) : (filt_r - cfg.dry_point);
  assign den_neg = (cfg.wet_point < cfg.dry_point);
  assign den_mag = den_neg ? (cfg.dry_point - cfg.wet_point) : (cfg.wet_point - cfg.dry_point);

  // operand select for the one shared multiplier
  always_comb begin
    unique case (ctrl.op)
      OP_ACC_HIST: begin
        mul_a = above;
        mul_b = MB_W'(weight);
      end
      OP_ACC_NEW: begin
        mul_a = sample_r;
        mul_b = MB_W'(AVG_LENGTH);
      end
      OP_MAP: begin
        mul_a = num_mag;
        mul_b = MB_W'(PCT_SCALE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign acc_sum = acc_r + SUM_W'(prod);

  assign div_load = ctrl.go && (ctrl.op == OP_ACC_NEW || ctrl.op == OP_MAP);
  assign div_step = ctrl.go && (ctrl.op == OP_DIV_STEP);
  assign div_dvd  = (ctrl.op == OP_MAP) ? DVD_W'(prod) : DVD_W'(acc_sum);
  assign div_dvs  = (ctrl.op == OP_MAP) ? DVS_W'(den_mag) : DVS_W'(wsum_r + WSUM_W'(AVG_LENGTH));

  msc_divider #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .step     (div_step),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .last     (div_last)
  );

  assign quo_pct   = PCT_W'(div_quo);
  assign moist_val = cal_err ? '0 : (sign_r ? (~quo_pct + 1'b1) : quo_pct);

  // alarm holds on equality and on a calibration error
  always_comb begin
    alarm_nxt = alarm_r;
    if (!cal_err) begin
      if ($signed(moist_val) < $signed({{(PCT_W-LEVEL_W){1'b0}}, cfg.min_level})) begin
        alarm_nxt = 1'b1;
      end else if ($signed(moist_val) > $signed({{(PCT_W-LEVEL_W){1'b0}}, cfg.min_level})) begin
        alarm_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AVG_LENGTH; i++) begin
        hist_r[i] <= '0;
      end
      alarm_r <= 1'b0;
    end else if (ctrl.go) begin
      if (ctrl.op == OP_ACC_NEW) begin
        // all slots move at once; an empty slot above leaves the slot as is
        for (int i = 0; i < AVG_LENGTH - 1; i++) begin
          if (hist_r[i+1] != '0) begin
            hist_r[i] <= hist_r[i+1];
          end
        end
        hist_r[AVG_LENGTH-1] <= sample_r;
      end
      if (ctrl.op == OP_EMIT) begin
        alarm_r <= alarm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      unique case (ctrl.op)
        OP_LATCH: begin
          sample_r <= in_sample;
          acc_r    <= '0;
          wsum_r   <= '0;
          idx_r    <= '0;
        end
        OP_PASS: begin
          filt_r <= sample_r;
        end
        OP_ACC_HIST: begin
          if (above != '0) begin
            acc_r  <= acc_sum;
            wsum_r <= wsum_r + WSUM_W'(weight);
          end
          idx_r <= idx_r + 1'b1;
        end
        OP_TAKE_AVG: begin
          filt_r <= div_quo[SAMPLE_W-1:0];
        end
        OP_MAP: begin
          sign_r <= num_neg ^ den_neg;
        end
        OP_EMIT: begin
          moist_r     <= moist_val;
          out_filt_r  <= filt_r;
          out_alarm_r <= alarm_nxt;
          out_cal_r   <= cal_err;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.avg_on   = cfg.use_avg;
  assign stat.cal_err  = cal_err;
  assign stat.idx_last = (idx_r == IDX_W'(AVG_LENGTH - 2));
  assign stat.div_last = div_last;

  assign moisture_percent  = moist_r;
  assign filtered_value    = out_filt_r;
  assign low_alarm         = out_alarm_r;
  assign calibration_error = out_cal_r;

endmodule

### rtl/msc_sequencer.sv
// msc_sequencer: step counter over the control store, with conditional jumps
// depends on msc_pkg

module msc_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_free,
  input  msc_pkg::msc_stat_t  stat,
  output msc_pkg::msc_ctrl_t  ctrl,
  output logic                in_stall
);

  import msc_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  ucode_t          uw;
  logic            go;

  assign uw = ucode_rom(pc_r);

  always_comb begin
    go     = 1'b1;
    pc_nxt = pc_r + 1'b1;
    unique case (uw.cond)
      C_NEXT: begin
      end
      C_JUMP: begin
        pc_nxt = uw.target;
      end
      C_WAIT_IN: begin
        go     = in_valid;
        pc_nxt = in_valid ? uw.target : pc_r;
      end
      C_WAIT_OUT: begin
        go     = out_free;
        pc_nxt = out_free ? uw.target : pc_r;
      end
      C_JMP_NOAVG: begin
        if (!stat.avg_on) pc_nxt = uw.target;
      end
      C_JMP_CAL: begin
        if (stat.cal_err) pc_nxt = uw.target;
      end
      C_LOOP_IDX: begin
        if (!stat.idx_last) pc_nxt = uw.target;
      end
      C_LOOP_DIV: begin
        if (!stat.div_last) pc_nxt = uw.target;
      end
      default: begin
        pc_nxt = PC_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl.op  = uw.op;
  assign ctrl.go  = go;
  assign in_stall = (uw.cond != C_WAIT_IN);

endmodule

### rtl/moisture_sample_conditioner.sv
// moisture_sample_conditioner: top level with register port, output register and checks
// depends on msc_pkg, msc_sequencer, msc_datapath (and through it msc_divider)

// Conditions one 10-bit moisture sample per transaction: optional linearly
// weighted moving average over AVG_LENGTH history slots (empty slots skipped),
// then a linear map from dry_point..wet_point onto 0..100 percent, truncated
// and unclamped, plus a low alarm that holds on equality. Equal calibration
// points give calibration_error with 0 percent. One transaction is worked at a
// time by a microcoded sequencer driving one multiplier and one restoring
// divider that yields a bit per cycle. The divider works on D = max(17, bits of
// 1023*AVG_LENGTH*(AVG_LENGTH+1)/2) bits (17 at AVG_LENGTH = 8). An item runs two
// divides with averaging on, one for the average and one for the map, and only
// the map divide without; a calibration error removes the map divide. The result
// sits in an output register, so the next transaction is taken while it waits.
// Registers: 0x0 use_average, 0x4 min_level, 0x8 dry_point, 0xC wet_point.

module moisture_sample_conditioner #(
  parameter int AVG_LENGTH = msc_pkg::DEF_AVG_LENGTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [msc_pkg::SAMPLE_W-1:0]  in_adc_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [msc_pkg::PCT_W-1:0]     out_moisture_percent,
  output logic [msc_pkg::SAMPLE_W-1:0]  out_filtered_value,
  output logic                          out_low_alarm,
  output logic                          out_calibration_error,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msc_pkg::ADDR_W-1:0]    paddr,
  input  logic [msc_pkg::DATA_W-1:0]    pwdata,
  output logic [msc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  import msc_pkg::*;

  msc_cfg_t  cfg_r;
  msc_ctrl_t ctrl;
  msc_stat_t stat;
  logic      out_valid_r;
  logic      out_free;
  logic      emit;
  logic      cfg_wr;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.use_avg   <= 1'b0;
      cfg_r.min_level <= '0;
      cfg_r.dry_point <= DRY_RESET;
      cfg_r.wet_point <= WET_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_USE_AVG:   cfg_r.use_avg   <= pwdata[0];
        REG_MIN_LEVEL: cfg_r.min_level <= pwdata[LEVEL_W-1:0];
        REG_DRY_POINT: cfg_r.dry_point <= pwdata[SAMPLE_W-1:0];
        REG_WET_POINT: cfg_r.wet_point <= pwdata[SAMPLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_USE_AVG:   prdata = DATA_W'(cfg_r.use_avg);
      REG_MIN_LEVEL: prdata = DATA_W'(cfg_r.min_level);
      REG_DRY_POINT: prdata = DATA_W'(cfg_r.dry_point);
      REG_WET_POINT: prdata = DATA_W'(cfg_r.wet_point);
      default:       prdata = '0;
    endcase
  end

  // the output register may be reloaded in the cycle its transaction leaves
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = ctrl.go && (ctrl.op == OP_EMIT);

  msc_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_stall (in_stall)
  );

  msc_datapath #(
    .AVG_LENGTH (AVG_LENGTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .cfg               (cfg_r),
    .in_sample         (in_adc_sample),
    .stat              (stat),
    .moisture_percent  (out_moisture_percent),
    .filtered_value    (out_filtered_value),
    .low_alarm         (out_low_alarm),
    .calibration_error (out_calibration_error)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  // one transaction in flight: an accepted sample blocks the next one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a sample is in work");

  a_cal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_calibration_error |-> out_moisture_percent == '0)
    else $error("calibration error with nonzero moisture");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(emit))
    else $error("result appeared without an emit step");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// testbench for moisture_sample_conditioner: predicts every reading and checks it on the fly
// depends on msc_pkg and the moisture_sample_conditioner rtl, nothing else

module testbench;
  import msc_pkg::*;

  localparam int HIST_DEPTH = DEF_AVG_LENGTH;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 125;

  typedef struct packed {
    logic [PCT_W-1:0]    pct;
    logic [SAMPLE_W-1:0] filt;
    logic                alarm;
    logic                cal_err;
  } reading_t;

  class moisture_scoreboard;
    logic                avg_on;
    logic [LEVEL_W-1:0]  min_lvl;
    logic [SAMPLE_W-1:0] dry_pt;
    logic [SAMPLE_W-1:0] wet_pt;
    logic [SAMPLE_W-1:0] slots [HIST_DEPTH];
    logic                alarm;
    reading_t            awaited_readings[$];
    int unsigned         mismatches;

    function new();
      avg_on = 1'b0;
      min_lvl = '0;
      dry_pt = DRY_RESET;
      wet_pt = WET_RESET;
      foreach (slots[i]) slots[i] = '0;
      alarm = 1'b0;
      mismatches = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_USE_AVG:   avg_on = value[0];
        REG_MIN_LEVEL: min_lvl = value[LEVEL_W-1:0];
        REG_DRY_POINT: dry_pt = value[SAMPLE_W-1:0];
        REG_WET_POINT: wet_pt = value[SAMPLE_W-1:0];
        default: ;
      endcase
    endfunction

    function void flag(string what);
      if (mismatches < 10) $display("%0t: %s", $time, what);
      mismatches++;
    endfunction

    function int pending();
      return awaited_readings.size();
    endfunction

    // weighted average over the history when averaging is on, then the linear map and the alarm band
    function void record_sample(logic [SAMPLE_W-1:0] adc);
      reading_t exp;
      logic [SAMPLE_W-1:0] shifted [HIST_DEPTH];
      int unsigned acc;
      int unsigned wsum;
      int pct;
      int num;
      int den;
      exp.filt = adc;
      if (avg_on) begin
        acc = adc * HIST_DEPTH;
        wsum = HIST_DEPTH;
        for (int i = 0; i < HIST_DEPTH - 1; i++) begin
          // an empty slot does not move down and carries no weight
          if (slots[i+1] != '0) begin
            shifted[i] = slots[i+1];
            acc += slots[i+1] * (i + 1);
            wsum += i + 1;
          end else begin
            shifted[i] = slots[i];
          end
        end
        shifted[HIST_DEPTH-1] = adc;
        slots = shifted;
        exp.filt = SAMPLE_W'(acc / wsum);
      end
      pct = 0;
      exp.cal_err = (wet_pt == dry_pt);
      if (!exp.cal_err) begin
        num = (int'(exp.filt) - int'(dry_pt)) * PCT_SCALE;
        den = int'(wet_pt) - int'(dry_pt);
        pct = num / den;
        if (pct < int'(min_lvl)) alarm = 1'b1;
        else if (pct > int'(min_lvl)) alarm = 1'b0;
      end
      exp.pct = pct[PCT_W-1:0];
      exp.alarm = alarm;
      awaited_readings.push_back(exp);
    endfunction

    function void check_reading(reading_t got);
      reading_t exp;
      if (awaited_readings.size() == 0) begin
        flag($sformatf("reading with nothing awaited: pct %0d filt %0d alarm %0b cal %0b",
                       $signed(got.pct), got.filt, got.alarm, got.cal_err));
        return;
      end
      exp = awaited_readings.pop_front();
      if (got.pct !== exp.pct || got.filt !== exp.filt || got.alarm !== exp.alarm ||
          got.cal_err !== exp.cal_err)
        flag($sformatf("reading: pct %0d/%0d filt %0d/%0d alarm %b/%b cal %b/%b (exp/got)",
                       $signed(exp.pct), $signed(got.pct), exp.filt, got.filt,
                       exp.alarm, got.alarm, exp.cal_err, got.cal_err));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [SAMPLE_W-1:0] in_adc_sample;
  logic out_valid;
  logic out_stall;
  logic [PCT_W-1:0] out_moisture_percent;
  logic [SAMPLE_W-1:0] out_filtered_value;
  logic out_low_alarm;
  logic out_calibration_error;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  moisture_scoreboard sb;
  bit steady;

  moisture_sample_conditioner DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_adc_sample        (in_adc_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_moisture_percent (out_moisture_percent),
    .out_filtered_value   (out_filtered_value),
    .out_low_alarm        (out_low_alarm),
    .out_calibration_error(out_calibration_error),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned draw_gap();
    return steady ? 0 : $urandom_range(0, 10);
  endfunction

  // skewed towards empty-slot zeros, full scale and the alarm threshold
  function automatic logic [SAMPLE_W-1:0] draw_sample();
    int target;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 10'd1023;
      2: return SAMPLE_W'($urandom_range(0, 15));
      3: begin
        target = int'(sb.dry_pt) + ((int'(sb.wet_pt) - int'(sb.dry_pt)) * int'(sb.min_lvl))
                 / PCT_SCALE + int'($urandom_range(0, 2)) - 1;
        if (target < 0) target = 0;
        if (target > 1023) target = 1023;
        return target[SAMPLE_W-1:0];
      end
      default: return SAMPLE_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic apb_transfer(input logic wr, input logic [1:0] idx,
                              input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_register(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] rd;
    apb_transfer(1'b1, idx, value, rd);
    sb.set_register(idx, value);
    apb_transfer(1'b0, idx, '0, rd);
    if (rd !== value)
      sb.flag($sformatf("register %0d read back %0h, wrote %0h", idx, rd, value));
  endtask

  task automatic setup_point(input logic avg, input int lvl, input int dry, input int wet);
    program_register(REG_USE_AVG, DATA_W'(avg));
    program_register(REG_MIN_LEVEL, lvl);
    program_register(REG_DRY_POINT, dry);
    program_register(REG_WET_POINT, wet);
  endtask

  // valid stays high into the next transaction when no gap is drawn
  task automatic send_sample(input logic [SAMPLE_W-1:0] adc);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_adc_sample <= adc;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.record_sample(adc);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // result side: stall for a drawn number of cycles, then take one transaction
  initial begin
    int unsigned gap;
    reading_t got;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = '{out_moisture_percent, out_filtered_value, out_low_alarm, out_calibration_error};
      sb.check_reading(got);
      @(negedge clk);
    end
  end

  initial begin
    int dry;
    int wet;
    int lvl;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_adc_sample = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // straight through at the reset calibration, full scale both ways
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd1);
    send_sample(10'd512);
    send_sample(10'd511);
    // alarm sets below the level, holds on equality, clears above
    settle();
    program_register(REG_MIN_LEVEL, 50);
    send_sample(10'd1023);
    send_sample(10'd511);
    send_sample(10'd0);
    send_sample(10'd511);
    // averaging from an empty history, a zero sample leaves an empty slot behind
    settle();
    program_register(REG_USE_AVG, 1);
    send_sample(10'd700);
    send_sample(10'd0);
    send_sample(10'd300);
    for (int i = 1; i <= 9; i++) send_sample(SAMPLE_W'(i * 100));
    send_sample(10'd1023);
    // equal calibration points hold the alarm
    settle();
    setup_point(1'b0, 127, 512, 512);
    send_sample(10'd0);
    send_sample(10'd1023);
    // steepest slopes give the widest percentages
    settle();
    program_register(REG_DRY_POINT, 0);
    program_register(REG_WET_POINT, 1);
    send_sample(10'd1023);
    send_sample(10'd0);
    settle();
    program_register(REG_DRY_POINT, 1022);
    program_register(REG_WET_POINT, 1023);
    send_sample(10'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: lvl = 0;
        1: lvl = 100;
        2: lvl = 127;
        default: lvl = $urandom_range(0, 127);
      endcase
      case (ph % 6)
        0: begin dry = 1023; wet = 0; end
        1: begin dry = 0; wet = 1023; end
        2: begin dry = $urandom_range(0, 1023); wet = dry; end
        3: begin dry = 1023; wet = 1022; end
        4: begin dry = 0; wet = 1; end
        default: begin dry = $urandom_range(0, 1023); wet = $urandom_range(0, 1023); end
      endcase
      setup_point((ph >= 6), lvl, dry, wet);
      repeat (PHASE_ITEMS) send_sample(draw_sample());
    end

    settle();
    steady = 1'b0;
    repeat (64) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
